// File: hw/rtl/rrd_pkg.sv
// shared types and constants of the request deframer
package rrd_pkg;

  localparam int unsigned MAX_DEPTH_DEF  = 4;
  localparam int unsigned LEN_BITS_DEF   = 30;
  localparam int unsigned CFG_W          = 30;
  localparam logic [CFG_W-1:0] MAX_LEN_RESET = 30'd536870912;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    PH_TYPE,
    PH_LEN,
    PH_HDR_LF,
    PH_PAYLOAD,
    PH_DATA_CR,
    PH_DATA_LF,
    PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    LT_ARRAY,
    LT_BULK,
    LT_INT
  } line_e;

  typedef enum logic [2:0] {
    KIND_DATA,
    KIND_EMPTY,
    KIND_NULL,
    KIND_END,
    KIND_ERROR
  } kind_e;

  typedef enum logic [2:0] {
    ERR_BAD_TYPE,
    ERR_BAD_DIGIT,
    ERR_OVER_LIMIT,
    ERR_TOO_DEEP,
    ERR_NO_CRLF
  } err_e;

  typedef struct packed {
    logic  valid;
    kind_e kind;
    logic [7:0] data;
    logic  token_last;
    logic  command_last;
    err_e  code;
  } res_t;

  typedef struct packed {
    logic done;
    logic push;
    logic clear;
  } stk_req_t;

  typedef struct packed {
    logic full;
    logic cmd_last;
  } stk_stat_t;

endpackage

// File: hw/rtl/rrd_ifs.sv
// stream and configuration channel interfaces of the request deframer
interface rrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_req;
  modport source (output valid, output byte_req, input ready);
  modport sink (input valid, input byte_req, output ready);
endinterface

interface rrd_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] data;
  logic       token_last;
  logic       command_last;
  logic [2:0] error_code;
  modport source (output valid, output kind, output data, output token_last,
                  output command_last, output error_code, input ready);
  modport sink (input valid, input kind, input data, input token_last,
                input command_last, input error_code, output ready);
endinterface

interface rrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [29:0] max_length;
  modport source (output valid, output max_length, input ready);
  modport sink (input valid, input max_length, output ready);
endinterface

// File: hw/rtl/rrd_in_reg.sv
// input byte register of the request deframer
module rrd_in_reg (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  logic [7:0] byte_i,
  input  logic       out_free_i,
  output logic       ready_o,
  output logic       step_o,
  output logic [7:0] byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign ready_o = !valid_q || out_free_i;
  assign step_o  = valid_q && out_free_i;
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      byte_q <= byte_i;
    end
  end

endmodule

// File: hw/rtl/rrd_count_stack.sv
// stack of remaining element counts, one entry per open array
module rrd_count_stack import rrd_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int unsigned LEN_BITS  = LEN_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  stk_req_t            req_i,
  input  logic [LEN_BITS-1:0] push_val_i,
  output stk_stat_t           stat_o
);

  localparam int unsigned DW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  logic [LEN_BITS-1:0] cnt_q [MAX_DEPTH];
  logic [DW-1:0]       depth_q, depth_d;
  logic [MAX_DEPTH-1:0] stop;
  logic [IW-1:0]       sel;
  logic                found;

  // a level stops the pop cascade when it is open and does not reach zero
  always_comb begin
    sel   = '0;
    found = 1'b0;
    for (int unsigned k = 0; k < MAX_DEPTH; k++) begin
      stop[k] = (DW'(k) < depth_q) && (cnt_q[k] != LEN_BITS'(1));
      if (stop[k]) begin
        sel   = IW'(k);
        found = 1'b1;
      end
    end
  end

  assign stat_o.full     = (depth_q >= DW'(MAX_DEPTH));
  assign stat_o.cmd_last = !found;

  always_comb begin
    depth_d = depth_q;
    if (req_i.clear) begin
      depth_d = '0;
    end else if (req_i.push) begin
      depth_d = depth_q + DW'(1);
    end else if (req_i.done) begin
      depth_d = found ? (DW'(sel) + DW'(1)) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
    end else begin
      depth_q <= depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned k = 0; k < MAX_DEPTH; k++) begin
      if (!req_i.clear && req_i.push && (DW'(k) == depth_q)) begin
        cnt_q[k] <= push_val_i;
      end else if (!req_i.clear && req_i.done && found && (IW'(k) == sel)) begin
        cnt_q[k] <= cnt_q[k] - LEN_BITS'(1);
      end
    end
  end

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_DEPTH)) else $error("stack depth beyond limit");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.push |-> !stat_o.full) else $error("push into full stack");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clear |=> depth_q == '0) else $error("stack not emptied");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.push && !req_i.clear) |=> depth_q == $past(depth_q) + DW'(1))
    else $error("push did not grow stack");

endmodule

// File: hw/rtl/rrd_parser.sv
// header and payload state machine of the request deframer
module rrd_parser import rrd_pkg::*; #(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [CFG_W-1:0]    max_length_i,
  input  stk_stat_t           stk_i,
  output stk_req_t            stk_o,
  output logic [LEN_BITS-1:0] push_val_o,
  output res_t                res_o
);

  localparam int unsigned CW = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;

  phase_e              phase_q, phase_d;
  line_e               line_q, line_d;
  logic [LEN_BITS-1:0] acc_q, acc_d;
  logic                neg_q, neg_d;
  logic                dig_q, dig_d;
  logic [LEN_BITS-1:0] left_q, left_d;

  logic [LEN_BITS+3:0] v_wide;
  logic [LEN_BITS-1:0] v_sat;
  logic [LEN_BITS-1:0] left_dec;
  logic                is_digit;
  logic                err;
  err_e                err_code;

  // acc * 10 + digit, saturated to the length width
  assign v_wide = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1)
                + (LEN_BITS + 4)'(byte_i[3:0]);
  assign v_sat  = (|v_wide[LEN_BITS+3:LEN_BITS]) ? '1 : v_wide[LEN_BITS-1:0];
  assign left_dec = left_q - LEN_BITS'(1);
  assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign push_val_o = acc_q;

  always_comb begin
    phase_d  = phase_q;
    line_d   = line_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    dig_d    = dig_q;
    left_d   = left_q;
    stk_o    = '0;
    res_o    = '0;
    err      = 1'b0;
    err_code = ERR_BAD_TYPE;
    if (step_i) begin
      unique case (phase_q)
        PH_TYPE: begin
          acc_d = '0;
          neg_d = 1'b0;
          dig_d = 1'b0;
          phase_d = PH_LEN;
          priority if (byte_i == CH_STAR) begin
            line_d = LT_ARRAY;
          end else if (byte_i == CH_DOLLAR) begin
            line_d = LT_BULK;
          end else if (byte_i == CH_COLON) begin
            line_d = LT_INT;
          end else begin
            err = 1'b1;
            err_code = ERR_BAD_TYPE;
          end
        end
        PH_LEN: begin
          priority if (byte_i == CH_MINUS && !dig_q && !neg_q) begin
            neg_d = 1'b1;
          end else if (is_digit) begin
            dig_d = 1'b1;
            if (line_q != LT_INT && !neg_q
                && (CW'(v_sat) > CW'(max_length_i))) begin
              err = 1'b1;
              err_code = ERR_OVER_LIMIT;
            end else begin
              acc_d = v_sat;
            end
          end else if (byte_i == CH_CR && dig_q) begin
            phase_d = PH_HDR_LF;
          end else begin
            err = 1'b1;
            err_code = ERR_BAD_DIGIT;
          end
        end
        PH_HDR_LF: begin
          phase_d = PH_TYPE;
          priority if (byte_i != CH_LF) begin
            err = 1'b1;
            err_code = ERR_NO_CRLF;
          end else if (line_q == LT_INT || neg_q || (line_q == LT_ARRAY && acc_q == '0)
                       || (line_q == LT_BULK && acc_q == '0)) begin
            stk_o.done = 1'b1;
            res_o.valid = 1'b1;
            res_o.token_last = 1'b1;
            res_o.command_last = stk_i.cmd_last;
            if (line_q == LT_INT) begin
              res_o.kind = KIND_END;
            end else if (neg_q) begin
              res_o.kind = KIND_NULL;
            end else if (line_q == LT_ARRAY) begin
              res_o.kind = KIND_END;
            end else begin
              res_o.kind = KIND_EMPTY;
              phase_d = PH_DATA_CR;
            end
          end else if (line_q == LT_ARRAY) begin
            if (stk_i.full) begin
              err = 1'b1;
              err_code = ERR_TOO_DEEP;
            end else begin
              stk_o.push = 1'b1;
            end
          end else begin
            left_d = acc_q;
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          left_d = left_dec;
          res_o.valid = 1'b1;
          res_o.kind = KIND_DATA;
          res_o.data = byte_i;
          if (left_dec == '0) begin
            stk_o.done = 1'b1;
            res_o.token_last = 1'b1;
            res_o.command_last = stk_i.cmd_last;
            phase_d = PH_DATA_CR;
          end
        end
        PH_DATA_CR: begin
          phase_d = PH_DATA_LF;
          if (byte_i != CH_CR) begin
            err = 1'b1;
            err_code = ERR_NO_CRLF;
          end
        end
        PH_DATA_LF: begin
          phase_d = PH_TYPE;
          if (byte_i != CH_LF) begin
            err = 1'b1;
            err_code = ERR_NO_CRLF;
          end
        end
        PH_SKIP: begin
          if (byte_i == CH_LF) begin
            phase_d = PH_TYPE;
          end
        end
        default: begin
          phase_d = PH_SKIP;
        end
      endcase

      // error: one result, stack cleared, drop up to the next line feed
      if (err) begin
        stk_o = '0;
        stk_o.clear = 1'b1;
        acc_d  = '0;
        neg_d  = 1'b0;
        dig_d  = 1'b0;
        left_d = '0;
        phase_d = (byte_i == CH_LF && err_code != ERR_TOO_DEEP) ? PH_TYPE : PH_SKIP;
        res_o = '0;
        res_o.valid = 1'b1;
        res_o.kind  = KIND_ERROR;
        res_o.code  = err_code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      line_q  <= LT_ARRAY;
      acc_q   <= '0;
      neg_q   <= 1'b0;
      dig_q   <= 1'b0;
      left_q  <= '0;
    end else begin
      phase_q <= phase_d;
      line_q  <= line_d;
      acc_q   <= acc_d;
      neg_q   <= neg_d;
      dig_q   <= dig_d;
      left_q  <= left_d;
    end
  end

endmodule

// File: hw/rtl/rrd_out_reg.sv
// result register of the request deframer
module rrd_out_reg import rrd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  res_t res_i,
  input  logic ready_i,
  output logic free_o,
  output res_t res_o
);

  logic valid_q;
  res_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    res_o = res_q;
    res_o.valid = valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= step_i && res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o) begin
      res_q <= res_i;
    end
  end

endmodule

// File: hw/rtl/resp_request_deframer.sv
// top level of the request deframer
//
//   channel | dir | payload              | transfer when
//   req_i   | in  | byte_req             | valid && ready
//   res_o   | out | kind, data, token_last, command_last, error_code | valid && ready
//   cfg_i   | in  | max_length           | valid && ready (ready always high)
//
// one byte per cycle sustained while the result register can drain; a byte waits in the input
// register, and its result, if any, is taken into the result register as the byte steps out;
// the step logic (type decode, decimal accumulate, stack pop scan) is one pass
// reset empties both registers, the count stack and the header state
// a stalled result holds the result register; the input register keeps
// taking a byte as long as the result register can drain or is empty
module resp_request_deframer import rrd_pkg::*; #(
  parameter int unsigned MAX_DEPTH = MAX_DEPTH_DEF,
  parameter int unsigned LEN_BITS  = LEN_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rrd_byte_if.sink     req_i,
  rrd_result_if.source res_o,
  rrd_cfg_if.sink      cfg_i
);

  logic [CFG_W-1:0]    max_len_q;
  logic                out_free;
  logic                step;
  logic [7:0]          byte_cur;
  stk_req_t            stk_req;
  stk_stat_t           stk_stat;
  logic [LEN_BITS-1:0] push_val;
  res_t                res_next;
  res_t                res_cur;

  // limit register; the user must write it only while the block is idle, the block does not enforce this
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_length;
    end
  end

  // input register: a byte steps forward whenever the result slot can take it
  rrd_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (req_i.valid),
    .byte_i     (req_i.byte_req),
    .out_free_i (out_free),
    .ready_o    (req_i.ready),
    .step_o     (step),
    .byte_o     (byte_cur)
  );

  // header and payload parsing
  rrd_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .byte_i       (byte_cur),
    .max_length_i (max_len_q),
    .stk_i        (stk_stat),
    .stk_o        (stk_req),
    .push_val_o   (push_val),
    .res_o        (res_next)
  );

  // open array counts, popped in one pass when elements finish
  rrd_count_stack #(
    .MAX_DEPTH (MAX_DEPTH),
    .LEN_BITS  (LEN_BITS)
  ) u_stack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (stk_req),
    .push_val_i (push_val),
    .stat_o     (stk_stat)
  );

  // result register toward the sink
  rrd_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .res_i   (res_next),
    .ready_i (res_o.ready),
    .free_o  (out_free),
    .res_o   (res_cur)
  );

  assign res_o.valid        = res_cur.valid;
  assign res_o.kind         = res_cur.kind;
  assign res_o.data         = res_cur.data;
  assign res_o.token_last   = res_cur.token_last;
  assign res_o.command_last = res_cur.command_last;
  assign res_o.error_code   = res_cur.code;

endmodule

// File: tb/rrd_checker.sv
// scoreboard: predicts deframer results from accepted bytes and compares them
`timescale 1ns / 100ps
module rrd_checker import rrd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  input  logic             req_ready_i,
  input  logic [7:0]       req_byte_i,
  input  logic             res_valid_i,
  input  logic             res_ready_i,
  input  logic [2:0]       res_kind_i,
  input  logic [7:0]       res_data_i,
  input  logic             res_token_last_i,
  input  logic             res_command_last_i,
  input  logic [2:0]       res_error_code_i,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [CFG_W-1:0] cfg_max_length_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output int unsigned      result_count_o,
  output int unsigned      error_count_o,
  output int unsigned      command_count_o
);

  localparam int unsigned DEPTH = MAX_DEPTH_DEF;
  localparam logic [LEN_BITS_DEF-1:0] LEN_ALL = '1;
  // code field reads zero on anything but an error
  localparam err_e NO_ERR = ERR_BAD_TYPE;

  phase_e                  ph;
  line_e                   lt;
  logic [LEN_BITS_DEF-1:0] acc;
  logic [LEN_BITS_DEF-1:0] left;
  logic                    neg;
  logic                    dig;
  logic [LEN_BITS_DEF-1:0] cnt [DEPTH];
  int unsigned             depth;
  logic [CFG_W-1:0]        max_len;
  res_t                    expected_q [$];
  int unsigned             fails, results, errors, commands;

  function automatic void clear_header();
    acc = '0;
    neg = 1'b0;
    dig = 1'b0;
  endfunction

  function automatic res_t make_res(kind_e k, logic [7:0] d, logic tl, logic cl, err_e c);
    res_t r;
    r = '0;
    r.valid        = 1'b1;
    r.kind         = k;
    r.data         = d;
    r.token_last   = tl;
    r.command_last = cl;
    r.code         = c;
    return r;
  endfunction

  // error: empty the stack and drop bytes up to the next line feed
  function automatic res_t parse_fault(err_e c, logic [7:0] b);
    depth = 0;
    clear_header();
    left = '0;
    ph = (b == CH_LF) ? PH_TYPE : PH_SKIP;
    return make_res(KIND_ERROR, 8'h00, 1'b0, 1'b0, c);
  endfunction

  // count one finished element off the open arrays, 1 when a command ends
  function automatic logic close_element();
    for (int n = 0; n <= DEPTH; n++) begin
      if (depth == 0 || depth > DEPTH) begin
        depth = 0;
        return 1'b1;
      end
      cnt[depth-1] = cnt[depth-1] - 1'b1;
      if (cnt[depth-1] != '0) return 1'b0;
      depth--;
    end
    depth = 0;
    return 1'b1;
  endfunction

  function automatic res_t deframe_byte(logic [7:0] b);
    res_t        r;
    logic [63:0] v;
    r = '0;
    case (ph)
      PH_TYPE: begin
        clear_header();
        if (b == CH_STAR) lt = LT_ARRAY;
        else if (b == CH_DOLLAR) lt = LT_BULK;
        else if (b == CH_COLON) lt = LT_INT;
        else return parse_fault(ERR_BAD_TYPE, b);
        ph = PH_LEN;
      end
      PH_LEN: begin
        if (b == CH_MINUS && !dig && !neg) begin
          neg = 1'b1;
        end else if (b >= CH_ZERO && b <= CH_NINE) begin
          dig = 1'b1;
          v = 64'(acc) * 10 + 64'(b - CH_ZERO);
          if (v > 64'(LEN_ALL)) v = 64'(LEN_ALL);
          if (lt != LT_INT && !neg && v > 64'(max_len))
            return parse_fault(ERR_OVER_LIMIT, b);
          acc = v[LEN_BITS_DEF-1:0];
        end else if (b == CH_CR && dig) begin
          ph = PH_HDR_LF;
        end else begin
          return parse_fault(ERR_BAD_DIGIT, b);
        end
      end
      PH_HDR_LF: begin
        if (b != CH_LF) return parse_fault(ERR_NO_CRLF, b);
        ph = PH_TYPE;
        if (lt == LT_INT) return make_res(KIND_END, 8'h00, 1'b1, close_element(), NO_ERR);
        if (neg) return make_res(KIND_NULL, 8'h00, 1'b1, close_element(), NO_ERR);
        if (lt == LT_ARRAY) begin
          if (acc == '0) return make_res(KIND_END, 8'h00, 1'b1, close_element(), NO_ERR);
          // too deep: the line feed does not end the drop here
          if (depth >= DEPTH) return parse_fault(ERR_TOO_DEEP, 8'h00);
          cnt[depth] = acc;
          depth++;
        end else if (acc == '0) begin
          r = make_res(KIND_EMPTY, 8'h00, 1'b1, close_element(), NO_ERR);
          ph = PH_DATA_CR;
        end else begin
          left = acc;
          ph = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        left = left - 1'b1;
        if (left == '0) begin
          r = make_res(KIND_DATA, b, 1'b1, close_element(), NO_ERR);
          ph = PH_DATA_CR;
        end else begin
          r = make_res(KIND_DATA, b, 1'b0, 1'b0, NO_ERR);
        end
      end
      PH_DATA_CR: begin
        if (b != CH_CR) return parse_fault(ERR_NO_CRLF, b);
        ph = PH_DATA_LF;
      end
      PH_DATA_LF: begin
        if (b != CH_LF) return parse_fault(ERR_NO_CRLF, b);
        ph = PH_TYPE;
      end
      default: begin
        if (b == CH_LF) ph = PH_TYPE;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d actual %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      ph = PH_TYPE;
      lt = LT_ARRAY;
      clear_header();
      left = '0;
      depth = 0;
      foreach (cnt[k]) cnt[k] = '0;
      max_len = MAX_LEN_RESET;
      expected_q.delete();
      fails = 0;
      results = 0;
      errors = 0;
      commands = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        results++;
        if (expected_q.size() == 0) begin
          $error("result transfer with none expected: kind %0d data %0d",
                 res_kind_i, res_data_i);
          fails++;
        end else begin
          want = expected_q.pop_front();
          check_field("kind", want.kind, res_kind_i);
          check_field("data", want.data, res_data_i);
          check_field("token_last", want.token_last, res_token_last_i);
          check_field("command_last", want.command_last, res_command_last_i);
          check_field("error_code", want.code, res_error_code_i);
          if (want.kind == KIND_ERROR) errors++;
          if (want.command_last) commands++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) max_len = cfg_max_length_i;
      if (req_valid_i && req_ready_i) begin
        want = deframe_byte(req_byte_i);
        if (want.valid) expected_q.insert(expected_q.size(), want);
      end
    end
    fail_count_o    <= fails;
    pending_o       <= expected_q.size();
    result_count_o  <= results;
    error_count_o   <= errors;
    command_count_o <= commands;
  end

endmodule

// File: tb/tb.sv
// testbench top: clock, reset, request byte stimulus and verdict for the deframer
`timescale 1ns / 100ps
module tb;
  import rrd_pkg::*;

  logic clk;
  logic rst_n;

  rrd_byte_if   req_if ();
  rrd_result_if res_if ();
  rrd_cfg_if    cfg_if ();

  // counters handed up by the scoreboard
  int unsigned fail_count, pending, result_count, error_count, command_count;

  logic        calm;      // no idling on either side while set
  logic        hold_ask;  // asks the result side for its one long stall
  logic [7:0]  byte_q [$];
  int unsigned bytes_sent;
  int unsigned settings_used;

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  resp_request_deframer u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  rrd_checker u_checker (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .req_valid_i        (req_if.valid),
    .req_ready_i        (req_if.ready),
    .req_byte_i         (req_if.byte_req),
    .res_valid_i        (res_if.valid),
    .res_ready_i        (res_if.ready),
    .res_kind_i         (res_if.kind),
    .res_data_i         (res_if.data),
    .res_token_last_i   (res_if.token_last),
    .res_command_last_i (res_if.command_last),
    .res_error_code_i   (res_if.error_code),
    .cfg_valid_i        (cfg_if.valid),
    .cfg_ready_i        (cfg_if.ready),
    .cfg_max_length_i   (cfg_if.max_length),
    .fail_count_o       (fail_count),
    .pending_o          (pending),
    .result_count_o     (result_count),
    .error_count_o      (error_count),
    .command_count_o    (command_count)
  );

  // hard stop well past the slowest correct run
  initial begin
    #(2_000_000);
    $display("resp_request_deframer test failed");
    $finish;
  end

  // result side: random stalls, plus one long hold-off counted here in cycles
  initial begin
    int unsigned hold_left;
    logic        hold_taken;
    hold_left  = 0;
    hold_taken = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= calm || ($urandom_range(99) >= 14);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // byte stream building
  // ---------------------------------------------------------------------------

  // append one byte to the stream being built
  task automatic add_byte(input logic [7:0] b);
    byte_q = {byte_q, b};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  // text followed by the CR LF line end
  task automatic add_line(input string s);
    add_text(s);
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic add_num(input longint unsigned n);
    add_text($sformatf("%0d", n));
  endtask

  // well-formed bulk string with random payload, any byte value allowed
  task automatic add_bulk(input int unsigned len);
    add_text("$");
    add_num(len);
    add_line("");
    repeat (len) add_byte(8'($urandom_range(255)));
    add_line("");
  endtask

  // one random element; arrays recurse and may now and then nest past the depth limit
  task automatic add_element(input int unsigned lvl);
    int unsigned pick, n;
    pick = $urandom_range(99);
    if (pick < 25 && (lvl < MAX_DEPTH_DEF || $urandom_range(19) == 0)) begin
      n = $urandom_range(1, 3);
      add_text("*");
      add_num(n);
      add_line("");
      repeat (n) add_element(lvl + 1);
    end else if (pick < 62) begin
      // mostly short tokens, a few longer ones
      if ($urandom_range(9) == 0) add_bulk($urandom_range(7, 24));
      else add_bulk($urandom_range(0, 6));
    end else if (pick < 74) begin
      // integer line, sometimes far past the accumulator width
      add_text(":");
      if ($urandom_range(1)) add_text("-");
      case ($urandom_range(2))
        0:       add_num($urandom_range(9));
        1:       add_num($urandom);
        default: add_num({$urandom, $urandom});
      endcase
      add_line("");
    end else if (pick < 84) begin
      // null values
      case ($urandom_range(2))
        0:       add_line("$-1");
        1:       add_line("*-1");
        default: add_line("$-0");
      endcase
    end else if (pick < 90) begin
      add_line("*0");
    end else begin
      add_bulk($urandom_range(1, 3));
    end
  endtask

  // ---------------------------------------------------------------------------
  // channel driving
  // ---------------------------------------------------------------------------

  // offer one byte, idling at random first, and wait for its transfer
  task automatic put_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 14) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.byte_req <= b;
    do @(posedge clk); while (!req_if.ready);
    bytes_sent++;
  endtask

  task automatic send_stream();
    while (byte_q.size() != 0) put_byte(byte_q.pop_front());
  endtask

  // stop offering, wait for every expected result, then let trailing
  // bytes that cause no result clear the two pipeline registers
  task automatic settle();
    req_if.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic set_max(input logic [CFG_W-1:0] v);
    settle();
    cfg_if.valid      <= 1'b1;
    cfg_if.max_length <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // random traffic: mostly well-formed elements, some noise and broken ones
  task automatic random_traffic(input int unsigned count);
    int unsigned stop_at, pick, pos;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
      end else begin
        add_element(0);
        if (pick >= 88) begin
          pos = $urandom_range(byte_q.size() - 1);
          // corrupt one byte, or cut the element short
          if (pick < 94) byte_q[pos] = 8'($urandom_range(255));
          else byte_q = byte_q[0:pos];
        end
      end
      send_stream();
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus and verdict
  // ---------------------------------------------------------------------------

  initial begin
    rst_n             = 1'b0;
    calm              = 1'b0;
    hold_ask          = 1'b0;
    bytes_sent        = 0;
    settings_used     = 1;
    req_if.valid      = 1'b0;
    req_if.byte_req   = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.max_length = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, limit at its reset value
    // array holding a bulk string and an integer
    add_line("*2");
    add_line("$3");
    add_line("abc");
    add_line(":-42");
    // bare empty string, its trailing line end still required
    add_line("$0");
    add_line("");
    // null bulk, null array as minus zero, empty array
    add_line("$-1");
    add_line("*-0");
    add_line("*0");
    // integer past the accumulator width saturates, no limit applies
    add_line(":99999999999999");
    // payload with line-end bytes and both extreme byte values
    add_line("$4");
    add_byte(8'h00);
    add_byte(CH_CR);
    add_byte(CH_LF);
    add_byte(8'hFF);
    add_line("");
    // nested arrays: the inner one closes on its bulk string, the outer on an empty array
    add_line("*2");
    add_line("*1");
    add_line("$1");
    add_line("a");
    add_line("*0");
    // length right at the limit is taken, then a bad digit
    add_text("$536870912x");
    add_line("");
    // one above the limit
    add_line("$536870913");
    // minus after a digit, error then ends on the line feed at once
    add_text("$7-");
    add_byte(CH_LF);
    // CR with no digit
    add_line("$");
    // bad type byte, rest of the line dropped
    add_text("!");
    add_line(":5");
    // fifth open array is too deep; its line feed does not end the drop
    repeat (5) add_line("*1");
    add_line(":1");
    add_line(":2");
    // missing line feed after a header CR
    add_text("*1");
    add_byte(CH_CR);
    add_line("x");
    // missing CR after a payload, and missing LF after the payload CR
    add_line("$1");
    add_text("zX");
    add_byte(CH_LF);
    add_line("$1");
    add_text("z");
    add_byte(CH_CR);
    add_line("Y");
    // line feed right after a payload: error, next byte is a type byte
    add_line("$1");
    add_text("z");
    add_byte(CH_LF);
    add_line(":3");
    send_stream();

    // limit zero: only empty strings, empty arrays, nulls and integers pass
    set_max('0);
    add_line("$0");
    add_line("");
    add_line("$1");
    add_line("*0");
    add_line("*1");
    add_line(":7");
    add_line("$-1");
    send_stream();
    random_traffic(50);

    // small limit, no idling on either side
    set_max(CFG_W'($urandom_range(3, 8)));
    calm <= 1'b1;
    random_traffic(200);
    calm <= 1'b0;

    // nearly full limit, all low bits set; result side holds off for a while
    // so the block fills up and stalls the byte input
    set_max({1'b0, {(CFG_W-1){1'b1}}});
    hold_ask <= 1'b1;
    random_traffic(220);

    // back to the reset limit
    set_max(MAX_LEN_RESET);
    random_traffic(170);

    settle();
    $display("covered %0d request bytes under %0d max_length settings", bytes_sent,
             settings_used);
    $display("checked %0d results: %0d errors, %0d completed commands", result_count,
             error_count, command_count);
    if (fail_count == 0) $display("resp_request_deframer test passed");
    else $display("resp_request_deframer test failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/rrd_pkg.sv
hw/rtl/rrd_ifs.sv
hw/rtl/rrd_in_reg.sv
hw/rtl/rrd_count_stack.sv
hw/rtl/rrd_parser.sv
hw/rtl/rrd_out_reg.sv
hw/rtl/resp_request_deframer.sv
tb/rrd_checker.sv
tb/tb.sv
